// File: sv/zcdp_pkg.sv
// types and constants shared by the zip central directory parser
package zcdp_pkg;

   localparam int unsigned POS_WIDTH = 18;

   // record layout, offsets within the fixed part
   localparam logic [POS_WIDTH-1:0] POS_SIG_END     = 18'd4;
   localparam logic [POS_WIDTH-1:0] POS_METHOD_LO   = 18'd10;
   localparam logic [POS_WIDTH-1:0] POS_METHOD_HI   = 18'd11;
   localparam logic [POS_WIDTH-1:0] POS_CRC         = 18'd16;
   localparam logic [POS_WIDTH-1:0] POS_PACKED      = 18'd20;
   localparam logic [POS_WIDTH-1:0] POS_PLAIN       = 18'd24;
   localparam logic [POS_WIDTH-1:0] POS_PLAIN_END   = 18'd28;
   localparam logic [POS_WIDTH-1:0] POS_NAME_LEN_LO = 18'd28;
   localparam logic [POS_WIDTH-1:0] POS_NAME_LEN_HI = 18'd29;
   localparam logic [POS_WIDTH-1:0] POS_EXTRA_LO    = 18'd30;
   localparam logic [POS_WIDTH-1:0] POS_EXTRA_HI    = 18'd31;
   localparam logic [POS_WIDTH-1:0] POS_COMMENT_LO  = 18'd32;
   localparam logic [POS_WIDTH-1:0] POS_COMMENT_HI  = 18'd33;
   localparam logic [POS_WIDTH-1:0] POS_OFFSET      = 18'd42;
   localparam logic [POS_WIDTH-1:0] FIXED_PART      = 18'd46;
   localparam logic [POS_WIDTH-1:0] FIXED_LAST      = 18'd45;
   // longest record is the fixed part plus three maximal lengths
   localparam logic [POS_WIDTH-1:0] MAX_POSITION    = 18'd196650;

   localparam logic [7:0] SLASH_CHAR = 8'h2F;
   localparam logic [7:0] SIGNATURE [4] = '{8'h50, 8'h4B, 8'h01, 8'h02};

   typedef struct packed {
      logic       valid;
      logic [7:0] data_byte;
   } zcdp_item_type;

   typedef struct packed {
      logic        name_byte_valid;
      logic [7:0]  name_byte;
      logic        entry_done;
      logic        bad_signature;
      logic [15:0] compression_method;
      logic [31:0] entry_crc;
      logic [31:0] packed_size;
      logic [31:0] plain_size;
      logic [15:0] name_length;
      logic [31:0] local_offset;
      logic        is_directory;
      logic        last_entry;
   } zcdp_result_type;

endpackage

// File: sv/zcdp_in_stage.sv
// input register stage with stall generation
module zcdp_in_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [7:0]             req_data_byte,
   output logic                   req_stall,
   input  logic                   advance,
   output zcdp_pkg::zcdp_item_type item
);
   import zcdp_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic [7:0] byte_in;
   logic       accept;
   logic       drain;

   // held byte can leave whenever the result register has room
   assign drain     = valid_ff & advance;
   assign req_stall = valid_ff & ~advance;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (accept) begin
         valid_in = 1'b1;
         byte_in  = req_data_byte;
      end else if (drain) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign item.valid     = valid_ff;
   assign item.data_byte = byte_ff;

endmodule

// File: sv/zcdp_field_engine.sv
// record position tracking, field gathering and per-byte result
module zcdp_field_engine (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     cfg_write,
   input  logic [15:0]              cfg_entry_count,
   input  logic                     step,
   input  logic [7:0]               data_byte,
   output zcdp_pkg::zcdp_result_type result
);
   import zcdp_pkg::*;

   logic [15:0]          entry_count_ff;
   logic [POS_WIDTH-1:0] position_ff, position_in;
   logic [15:0]          records_ff, records_in;
   logic [15:0]          method_ff, method_in;
   logic [31:0]          crc_ff, crc_in;
   logic [31:0]          packed_ff, packed_in;
   logic [31:0]          plain_ff, plain_in;
   logic [15:0]          name_len_ff, name_len_in;
   logic [15:0]          extra_len_ff, extra_len_in;
   logic [15:0]          comment_len_ff, comment_len_in;
   logic [31:0]          offset_ff, offset_in;
   logic [7:0]           final_char_ff, final_char_in;
   logic                 error_ff, error_in;

   logic                 active;
   logic                 sig_bad;
   logic                 record_end;
   logic [POS_WIDTH-1:0] total_len;
   logic [POS_WIDTH-1:0] name_end;
   logic [POS_WIDTH:0]   pos_plus_one;
   logic [1:0]           offset_lane;

   assign active       = ~error_ff & (records_ff < entry_count_ff);
   assign name_end     = FIXED_PART + POS_WIDTH'(name_len_ff);
   assign total_len    = name_end + POS_WIDTH'(extra_len_in) + POS_WIDTH'(comment_len_in);
   assign pos_plus_one = {1'b0, position_ff} + (POS_WIDTH+1)'(1);
   // offset field starts two lanes into a word boundary
   assign offset_lane  = position_ff[1:0] + 2'd2;

   always_comb begin
      position_in    = position_ff;
      records_in     = records_ff;
      method_in      = method_ff;
      crc_in         = crc_ff;
      packed_in      = packed_ff;
      plain_in       = plain_ff;
      name_len_in    = name_len_ff;
      extra_len_in   = extra_len_ff;
      comment_len_in = comment_len_ff;
      offset_in      = offset_ff;
      final_char_in  = final_char_ff;
      error_in       = error_ff;
      sig_bad        = 1'b0;
      record_end     = 1'b0;
      result         = '0;

      if (step && active) begin
         if (position_ff < POS_SIG_END) begin
            sig_bad = (data_byte != SIGNATURE[position_ff[1:0]]);
         end else if (position_ff == POS_METHOD_LO || position_ff == POS_METHOD_HI) begin
            method_in[{position_ff[0], 3'b000} +: 8] = data_byte;
         end else if (position_ff >= POS_CRC && position_ff < POS_PACKED) begin
            crc_in[{position_ff[1:0], 3'b000} +: 8] = data_byte;
         end else if (position_ff >= POS_PACKED && position_ff < POS_PLAIN) begin
            packed_in[{position_ff[1:0], 3'b000} +: 8] = data_byte;
         end else if (position_ff >= POS_PLAIN && position_ff < POS_PLAIN_END) begin
            plain_in[{position_ff[1:0], 3'b000} +: 8] = data_byte;
         end else if (position_ff == POS_NAME_LEN_LO || position_ff == POS_NAME_LEN_HI) begin
            name_len_in[{position_ff[0], 3'b000} +: 8] = data_byte;
         end else if (position_ff == POS_EXTRA_LO || position_ff == POS_EXTRA_HI) begin
            extra_len_in[{position_ff[0], 3'b000} +: 8] = data_byte;
         end else if (position_ff == POS_COMMENT_LO || position_ff == POS_COMMENT_HI) begin
            comment_len_in[{position_ff[0], 3'b000} +: 8] = data_byte;
         end else if (position_ff >= POS_OFFSET && position_ff < FIXED_PART) begin
            offset_in[{offset_lane, 3'b000} +: 8] = data_byte;
         end else if (position_ff >= FIXED_PART && position_ff < name_end) begin
            result.name_byte_valid = 1'b1;
            result.name_byte       = data_byte;
            final_char_in          = data_byte;
         end

         record_end = (position_ff >= FIXED_LAST) &&
                      (pos_plus_one >= {1'b0, total_len});

         if (sig_bad) begin
            error_in             = 1'b1;
            result.bad_signature = 1'b1;
         end else if (record_end) begin
            records_in                = records_ff + 16'd1;
            result.entry_done         = 1'b1;
            result.compression_method = method_in;
            result.entry_crc          = crc_in;
            result.packed_size        = packed_in;
            result.plain_size         = plain_in;
            result.name_length        = name_len_in;
            result.local_offset       = offset_in;
            result.is_directory       = (name_len_in != 16'd0) && (final_char_in == SLASH_CHAR);
            result.last_entry         = (records_in == entry_count_ff);
            position_in               = '0;
            final_char_in             = 8'd0;
         end else begin
            position_in = pos_plus_one[POS_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cfg_write) begin
         position_ff    <= '0;
         records_ff     <= 16'd0;
         method_ff      <= 16'd0;
         crc_ff         <= 32'd0;
         packed_ff      <= 32'd0;
         plain_ff       <= 32'd0;
         name_len_ff    <= 16'd0;
         extra_len_ff   <= 16'd0;
         comment_len_ff <= 16'd0;
         offset_ff      <= 32'd0;
         final_char_ff  <= 8'd0;
         error_ff       <= 1'b0;
      end else begin
         position_ff    <= position_in;
         records_ff     <= records_in;
         method_ff      <= method_in;
         crc_ff         <= crc_in;
         packed_ff      <= packed_in;
         plain_ff       <= plain_in;
         name_len_ff    <= name_len_in;
         extra_len_ff   <= extra_len_in;
         comment_len_ff <= comment_len_in;
         offset_ff      <= offset_in;
         final_char_ff  <= final_char_in;
         error_ff       <= error_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= 16'd0;
      end else if (cfg_write) begin
         entry_count_ff <= cfg_entry_count;
      end
   end

   a_position_bound: assert property (@(posedge clock) disable iff (reset)
      position_ff <= MAX_POSITION)
      else $error("record position past the longest possible record");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      records_ff <= entry_count_ff)
      else $error("parsed more records than configured");

   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      error_ff && !cfg_write |=> error_ff)
      else $error("signature error cleared without a restart");

endmodule

// File: sv/zcdp_out_stage.sv
// result register toward the response channel
module zcdp_out_stage (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       load,
   input  zcdp_pkg::zcdp_result_type  result,
   input  logic                       rsp_stall,
   output logic                       rsp_valid,
   output logic                       advance,
   output zcdp_pkg::zcdp_result_type  rsp_result
);
   import zcdp_pkg::*;

   logic            valid_ff;
   logic            valid_in;
   zcdp_result_type result_ff;
   zcdp_result_type result_in;

   // register is free when empty or when its transaction completes now
   assign advance = ~valid_ff | ~rsp_stall;

   always_comb begin
      valid_in  = valid_ff;
      result_in = result_ff;
      if (advance) begin
         valid_in  = load;
         result_in = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule

// File: sv/zip_central_directory_parser.sv
// top level of the zip central directory parser
//
// Bytes of a ZIP central directory enter on the req_ channel, one per
// transaction, and each byte yields exactly one transaction on the rsp_
// channel. A transaction moves when valid is high and stall is low.
// The rsp_ fields flag name bytes, a signature mismatch, and at the last
// byte of each record the gathered entry metadata.
// A byte lands in the input register, then one pass of position compare
// and field update fills the result register. Throughput is one byte per
// cycle while rsp_stall is low; a new byte is taken while the previous
// result waits. When the receiver stalls, the result register holds and
// req_stall rises only once the input register is also occupied.
// csr_entry_count sets the number of records to parse; each write restarts
// parsing from the start of a record and clears the error. csr_ready is
// high while no byte is in flight. Reset clears the count to zero, so bytes
// produce all-zero results until a count is written.
module zip_central_directory_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_name_byte_valid,
   output logic [7:0]  rsp_name_byte,
   output logic        rsp_entry_done,
   output logic        rsp_bad_signature,
   output logic [15:0] rsp_compression_method,
   output logic [31:0] rsp_entry_crc,
   output logic [31:0] rsp_packed_size,
   output logic [31:0] rsp_plain_size,
   output logic [15:0] rsp_name_length,
   output logic [31:0] rsp_local_offset,
   output logic        rsp_is_directory,
   output logic        rsp_last_entry,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_entry_count
);
   import zcdp_pkg::*;

   zcdp_item_type   item;
   zcdp_result_type result;
   zcdp_result_type rsp_result;
   logic            advance;
   logic            step;
   logic            cfg_write;

   assign step      = item.valid & advance;
   assign csr_ready = ~item.valid & ~rsp_valid;
   assign cfg_write = csr_valid & csr_ready;

   zcdp_in_stage u_in_stage (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_data_byte (req_data_byte),
      .req_stall     (req_stall),
      .advance       (advance),
      .item          (item)
   );

   zcdp_field_engine u_field_engine (
      .clock           (clock),
      .reset           (reset),
      .cfg_write       (cfg_write),
      .cfg_entry_count (csr_entry_count),
      .step            (step),
      .data_byte       (item.data_byte),
      .result          (result)
   );

   zcdp_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (step),
      .result     (result),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .advance    (advance),
      .rsp_result (rsp_result)
   );

   assign rsp_name_byte_valid    = rsp_result.name_byte_valid;
   assign rsp_name_byte          = rsp_result.name_byte;
   assign rsp_entry_done         = rsp_result.entry_done;
   assign rsp_bad_signature      = rsp_result.bad_signature;
   assign rsp_compression_method = rsp_result.compression_method;
   assign rsp_entry_crc          = rsp_result.entry_crc;
   assign rsp_packed_size        = rsp_result.packed_size;
   assign rsp_plain_size         = rsp_result.plain_size;
   assign rsp_name_length        = rsp_result.name_length;
   assign rsp_local_offset       = rsp_result.local_offset;
   assign rsp_is_directory       = rsp_result.is_directory;
   assign rsp_last_entry         = rsp_result.last_entry;

   a_done_xor_bad: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_entry_done && rsp_bad_signature))
      else $error("record end and signature error in one transaction");

   a_dir_needs_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_is_directory || rsp_last_entry) |-> rsp_entry_done)
      else $error("entry flags set outside a record end");

   a_stall_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> item.valid && rsp_valid)
      else $error("input stalled while a register stage is free");

endmodule
